// ===== hw/rtl/g2l_pkg.sv =====
// Package for the Gregorian to lunar date converter: widths, the year ROM
// contents and the days-before-month table. No dependencies.
package g2l_pkg;

    localparam int TableYears = 199;
    localparam int FirstYear  = 1901;
    localparam int MonthSteps = 12;

    typedef logic [23:0] year_word_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } greg_t;

    typedef struct packed {
        logic [3:0] lunar_month;
        logic [4:0] lunar_day;
        logic       leap_flag;
        logic [8:0] day_in_lunar_year;
        logic [3:0] stem_index;
        logic [3:0] branch_index;
        logic       range_error;
    } lunar_t;

    function automatic year_word_t year_word(input logic [7:0] idx);
        year_word_t w;
        begin
            w = 24'h0;
            unique case (idx)
                8'd0: w = 24'h04AE53; 8'd1: w = 24'h0A5748; 8'd2: w = 24'h5526BD;
                8'd3: w = 24'h0D2650; 8'd4: w = 24'h0D9544; 8'd5: w = 24'h46AAB9;
                8'd6: w = 24'h056A4D; 8'd7: w = 24'h09AD42; 8'd8: w = 24'h24AEB6;
                8'd9: w = 24'h04AE4A; 8'd10: w = 24'h6A4DBE; 8'd11: w = 24'h0A4D52;
                8'd12: w = 24'h0D2546; 8'd13: w = 24'h5D52BA; 8'd14: w = 24'h0B544E;
                8'd15: w = 24'h0D6A43; 8'd16: w = 24'h296D37; 8'd17: w = 24'h095B4B;
                8'd18: w = 24'h749BC1; 8'd19: w = 24'h049754; 8'd20: w = 24'h0A4B48;
                8'd21: w = 24'h5B25BC; 8'd22: w = 24'h06A550; 8'd23: w = 24'h06D445;
                8'd24: w = 24'h4ADAB8; 8'd25: w = 24'h02B64D; 8'd26: w = 24'h095742;
                8'd27: w = 24'h2497B7; 8'd28: w = 24'h04974A; 8'd29: w = 24'h664B3E;
                8'd30: w = 24'h0D4A51; 8'd31: w = 24'h0EA546; 8'd32: w = 24'h56D4BA;
                8'd33: w = 24'h05AD4E; 8'd34: w = 24'h02B644; 8'd35: w = 24'h393738;
                8'd36: w = 24'h092E4B; 8'd37: w = 24'h7C96BF; 8'd38: w = 24'h0C9553;
                8'd39: w = 24'h0D4A48; 8'd40: w = 24'h6DA53B; 8'd41: w = 24'h0B554F;
                8'd42: w = 24'h056A45; 8'd43: w = 24'h4AADB9; 8'd44: w = 24'h025D4D;
                8'd45: w = 24'h092D42; 8'd46: w = 24'h2C95B6; 8'd47: w = 24'h0A954A;
                8'd48: w = 24'h7B4ABD; 8'd49: w = 24'h06CA51; 8'd50: w = 24'h0B5546;
                8'd51: w = 24'h555ABB; 8'd52: w = 24'h04DA4E; 8'd53: w = 24'h0A5B43;
                8'd54: w = 24'h352BB8; 8'd55: w = 24'h052B4C; 8'd56: w = 24'h8A953F;
                8'd57: w = 24'h0E9552; 8'd58: w = 24'h06AA48; 8'd59: w = 24'h7AD53C;
                8'd60: w = 24'h0AB54F; 8'd61: w = 24'h04B645; 8'd62: w = 24'h4A5739;
                8'd63: w = 24'h0A574D; 8'd64: w = 24'h052642; 8'd65: w = 24'h3E9335;
                8'd66: w = 24'h0D9549; 8'd67: w = 24'h75AABE; 8'd68: w = 24'h056A51;
                8'd69: w = 24'h096D46; 8'd70: w = 24'h54AEBB; 8'd71: w = 24'h04AD4F;
                8'd72: w = 24'h0A4D43; 8'd73: w = 24'h4D26B7; 8'd74: w = 24'h0D254B;
                8'd75: w = 24'h8D52BF; 8'd76: w = 24'h0B5452; 8'd77: w = 24'h0B6A47;
                8'd78: w = 24'h696D3C; 8'd79: w = 24'h095B50; 8'd80: w = 24'h049B45;
                8'd81: w = 24'h4A4BB9; 8'd82: w = 24'h0A4B4D; 8'd83: w = 24'hAB25C2;
                8'd84: w = 24'h06A554; 8'd85: w = 24'h06D449; 8'd86: w = 24'h6ADA3D;
                8'd87: w = 24'h0AB651; 8'd88: w = 24'h093746; 8'd89: w = 24'h5497BB;
                8'd90: w = 24'h04974F; 8'd91: w = 24'h064B44; 8'd92: w = 24'h36A537;
                8'd93: w = 24'h0EA54A; 8'd94: w = 24'h86B2BF; 8'd95: w = 24'h05AC53;
                8'd96: w = 24'h0AB647; 8'd97: w = 24'h5936BC; 8'd98: w = 24'h092E50;
                8'd99: w = 24'h0C9645; 8'd100: w = 24'h4D4AB8; 8'd101: w = 24'h0D4A4C;
                8'd102: w = 24'h0DA541; 8'd103: w = 24'h25AAB6; 8'd104: w = 24'h056A49;
                8'd105: w = 24'h7AADBD; 8'd106: w = 24'h025D52; 8'd107: w = 24'h092D47;
                8'd108: w = 24'h5C95BA; 8'd109: w = 24'h0A954E; 8'd110: w = 24'h0B4A43;
                8'd111: w = 24'h4B5537; 8'd112: w = 24'h0AD54A; 8'd113: w = 24'h955ABF;
                8'd114: w = 24'h04BA53; 8'd115: w = 24'h0A5B48; 8'd116: w = 24'h652BBC;
                8'd117: w = 24'h052B50; 8'd118: w = 24'h0A9345; 8'd119: w = 24'h474AB9;
                8'd120: w = 24'h06AA4C; 8'd121: w = 24'h0AD541; 8'd122: w = 24'h24DAB6;
                8'd123: w = 24'h04B64A; 8'd124: w = 24'h69573D; 8'd125: w = 24'h0A4E51;
                8'd126: w = 24'h0D2646; 8'd127: w = 24'h5E933A; 8'd128: w = 24'h0D534D;
                8'd129: w = 24'h05AA43; 8'd130: w = 24'h36B537; 8'd131: w = 24'h096D4B;
                8'd132: w = 24'hB4AEBF; 8'd133: w = 24'h04AD53; 8'd134: w = 24'h0A4D48;
                8'd135: w = 24'h6D25BC; 8'd136: w = 24'h0D254F; 8'd137: w = 24'h0D5244;
                8'd138: w = 24'h5DAA38; 8'd139: w = 24'h0B5A4C; 8'd140: w = 24'h056D41;
                8'd141: w = 24'h24ADB6; 8'd142: w = 24'h049B4A; 8'd143: w = 24'h7A4BBE;
                8'd144: w = 24'h0A4B51; 8'd145: w = 24'h0AA546; 8'd146: w = 24'h5B52BA;
                8'd147: w = 24'h06D24E; 8'd148: w = 24'h0ADA42; 8'd149: w = 24'h355B37;
                8'd150: w = 24'h09374B; 8'd151: w = 24'h8497C1; 8'd152: w = 24'h049753;
                8'd153: w = 24'h064B48; 8'd154: w = 24'h66A53C; 8'd155: w = 24'h0EA54F;
                8'd156: w = 24'h06B244; 8'd157: w = 24'h4AB638; 8'd158: w = 24'h0AAE4C;
                8'd159: w = 24'h092E42; 8'd160: w = 24'h3C9735; 8'd161: w = 24'h0C9649;
                8'd162: w = 24'h7D4ABD; 8'd163: w = 24'h0D4A51; 8'd164: w = 24'h0DA545;
                8'd165: w = 24'h55AABA; 8'd166: w = 24'h056A4E; 8'd167: w = 24'h0A6D43;
                8'd168: w = 24'h452EB7; 8'd169: w = 24'h052D4B; 8'd170: w = 24'h8A95BF;
                8'd171: w = 24'h0A9553; 8'd172: w = 24'h0B4A47; 8'd173: w = 24'h6B553B;
                8'd174: w = 24'h0AD54F; 8'd175: w = 24'h055A45; 8'd176: w = 24'h4A5D38;
                8'd177: w = 24'h0A5B4C; 8'd178: w = 24'h052B42; 8'd179: w = 24'h3A93B6;
                8'd180: w = 24'h069349; 8'd181: w = 24'h7729BD; 8'd182: w = 24'h06AA51;
                8'd183: w = 24'h0AD546; 8'd184: w = 24'h54DABA; 8'd185: w = 24'h04B64E;
                8'd186: w = 24'h0A5743; 8'd187: w = 24'h452738; 8'd188: w = 24'h0D264A;
                8'd189: w = 24'h8E933E; 8'd190: w = 24'h0D5252; 8'd191: w = 24'h0DAA47;
                8'd192: w = 24'h66B53B; 8'd193: w = 24'h056D4F; 8'd194: w = 24'h04AE45;
                8'd195: w = 24'h4A4EB9; 8'd196: w = 24'h0A4D4C; 8'd197: w = 24'h0D1541;
                8'd198: w = 24'h2D92B5;
                default: w = 24'h0;
            endcase
            return w;
        end
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] mo);
        logic [8:0] r;
        begin
            unique case (mo)
                4'd1: r = 9'd0;    4'd2: r = 9'd31;   4'd3: r = 9'd59;
                4'd4: r = 9'd90;   4'd5: r = 9'd120;  4'd6: r = 9'd151;
                4'd7: r = 9'd181;  4'd8: r = 9'd212;  4'd9: r = 9'd243;
                4'd10: r = 9'd273; 4'd11: r = 9'd304; 4'd12: r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // size of one lunar year: 12 or 13 months of 29 or 30 days
    function automatic logic [8:0] lunar_year_len(input year_word_t w);
        logic [3:0] ones;
        logic [8:0] r;
        begin
            ones = 4'd0;
            for (int i = 0; i < 12; i++) begin
                ones = ones + {3'd0, w[19 - i]};
            end
            if (w[23:20] != 4'd0) begin
                r = 9'd377 + {5'd0, ones} + {8'd0, w[7]};
            end else begin
                r = 9'd348 + {5'd0, ones};
            end
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/g2l_front.sv =====
// Front end stages: range check, ROM lookup, day-of-year and offset from the
// spring festival. Depends on g2l_pkg.
module g2l_front #(
    parameter int TABLE_YEARS = g2l_pkg::TableYears,
    parameter int FIRST_YEAR  = g2l_pkg::FirstYear
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  g2l_pkg::greg_t      in_data,
    output logic                out_valid,
    output g2l_pkg::year_word_t out_word,
    output logic [8:0]          out_pos,
    output logic                out_err,
    output logic [3:0]          out_stem,
    output logic [3:0]          out_branch
);

    // stage A: index, error, day of year, stem/branch
    logic        a_valid_reg;
    logic [7:0]  a_idx_reg;
    logic        a_err_reg;
    logic [8:0]  a_now_reg;
    logic [3:0]  a_stem_reg;
    logic [3:0]  a_branch_reg;

    logic [12:0] idx_full;
    logic        bad_in;
    logic [1:0]  leap4;
    logic        leap_year;
    logic [8:0]  now_next;
    logic [12:0] y6, y8;
    logic [23:0] p100;
    logic [11:0] q100, r100;
    logic [25:0] p10, p12;
    logic [12:0] q10, q12, rem10, rem12;

    always_comb
    begin
        idx_full = {1'b0, in_data.year} - 13'(FIRST_YEAR);
        bad_in = (in_data.month == 4'd0) || (in_data.month > 4'd12) ||
                 (in_data.day == 5'd0) || ({1'b0, in_data.year} < 13'(FIRST_YEAR)) ||
                 (idx_full >= 13'(TABLE_YEARS));
        // year / 100 by reciprocal multiply, exact for 12-bit years
        p100 = {12'd0, in_data.year} * 24'd1311;
        q100 = {5'd0, p100[23:17]};
        r100 = in_data.year - q100 * 12'd100;
        leap4 = in_data.year[1:0];
        // century years are leap only when also a multiple of 16, i.e. of 400
        leap_year = (leap4 == 2'd0) &&
                    ((r100 != 12'd0) || (in_data.year[3:0] == 4'd0));
        now_next = g2l_pkg::days_before(in_data.month) + {4'd0, in_data.day} - 9'd1
                   + {8'd0, leap_year && (in_data.month > 4'd2)};
        y6 = {1'b0, in_data.year} + 13'd6;
        y8 = {1'b0, in_data.year} + 13'd8;
        p10 = {13'd0, y6} * 26'd6554;
        q10 = {3'd0, p10[25:16]};
        rem10 = y6 - q10 * 13'd10;
        p12 = {13'd0, y8} * 26'd5462;
        q12 = {3'd0, p12[25:16]};
        rem12 = y8 - q12 * 13'd12;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_idx_reg    <= idx_full[7:0];
            a_err_reg    <= bad_in;
            a_now_reg    <= now_next;
            a_stem_reg   <= rem10[3:0];
            a_branch_reg <= rem12[3:0];
        end
    end

    // stage B: ROM reads for this and the previous year
    logic                b_valid_reg;
    logic                b_err_reg;
    logic                b_first_reg;
    logic [8:0]          b_now_reg;
    g2l_pkg::year_word_t b_word_reg;
    g2l_pkg::year_word_t b_prev_reg;
    logic [3:0]          b_stem_reg;
    logic [3:0]          b_branch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_err_reg    <= a_err_reg;
            b_first_reg  <= (a_idx_reg == 8'd0);
            b_now_reg    <= a_now_reg;
            b_word_reg   <= g2l_pkg::year_word(a_idx_reg);
            b_prev_reg   <= g2l_pkg::year_word(a_idx_reg - 8'd1);
            b_stem_reg   <= a_stem_reg;
            b_branch_reg <= a_branch_reg;
        end
    end

    // stage C: offset from the spring festival, fall back to previous year
    logic [8:0] spring;
    logic       pre_fest;
    logic [8:0] pos_next;

    always_comb
    begin
        spring = {4'd0, b_word_reg[4:0]} - 9'd1;
        if (b_word_reg[6:5] != 2'd1)
        begin
            spring = spring + 9'd31;
        end
        pre_fest = b_now_reg < spring;
        if (pre_fest)
        begin
            pos_next = g2l_pkg::lunar_year_len(b_prev_reg) - (spring - b_now_reg);
        end
        else
        begin
            pos_next = b_now_reg - spring;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (advance)
        begin
            out_valid <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word   <= pre_fest ? b_prev_reg : b_word_reg;
            out_pos    <= pos_next;
            out_err    <= b_err_reg || (pre_fest && b_first_reg);
            out_stem   <= b_stem_reg;
            out_branch <= b_branch_reg;
        end
    end

endmodule

// ===== hw/rtl/g2l_month_step.sv =====
// One pipeline stage of the lunar month walk: subtract one month if the day
// offset reaches past it. Depends on g2l_pkg.
module g2l_month_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  g2l_pkg::year_word_t in_word,
    input  logic [8:0]          in_pos,
    input  logic [3:0]          in_m,
    input  logic [3:0]          in_lumon,
    input  logic                in_leap,
    input  logic                in_err,
    input  logic [8:0]          in_doy,
    input  logic [3:0]          in_stem,
    input  logic [3:0]          in_branch,
    output logic                out_valid,
    output g2l_pkg::year_word_t out_word,
    output logic [8:0]          out_pos,
    output logic [3:0]          out_m,
    output logic [3:0]          out_lumon,
    output logic                out_leap,
    output logic                out_err,
    output logic [8:0]          out_doy,
    output logic [3:0]          out_stem,
    output logic [3:0]          out_branch
);

    logic [8:0]  len;
    logic [3:0]  nmonths;
    logic        take;
    logic [19:0] mask;
    logic [3:0]  lumon_next;
    logic        leap_next;

    always_comb
    begin
        mask = 20'h80000 >> (in_m - 4'd1);
        len = ((in_word[19:0] & mask) != 20'd0) ? 9'd30 : 9'd29;
        nmonths = (in_word[23:20] != 4'd0) ? 4'd13 : 4'd12;
        take = (in_pos >= len) && (in_m < nmonths);
        lumon_next = in_lumon;
        leap_next  = in_leap;
        if (take)
        begin
            if (in_lumon == in_word[23:20])
            begin
                leap_next = !in_leap;
                if (in_leap)
                begin
                    lumon_next = in_lumon + 4'd1;
                end
            end
            else
            begin
                lumon_next = in_lumon + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (advance)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word   <= in_word;
            out_err    <= in_err;
            out_doy    <= in_doy;
            out_stem   <= in_stem;
            out_branch <= in_branch;
            out_pos    <= take ? in_pos - len : in_pos;
            out_m      <= take ? in_m + 4'd1 : in_m;
            out_lumon  <= lumon_next;
            out_leap   <= leap_next;
        end
    end

endmodule

// ===== hw/rtl/gregorian_to_lunar_date.sv =====
// Top level of the Gregorian to lunar date converter: stream ports, front
// stages, twelve month-walk stages and the output register.
// Depends on g2l_pkg, g2l_front and g2l_month_step.
//
// Usage: a request on the s_axis side carries one Gregorian date; one result
// per request comes out on m_axis, in order. The pipeline is 16 register
// stages deep (three front stages: range check, ROM read, festival offset;
// twelve month-walk stages, one lunar month each; one output register).
// A new request can enter in every cycle unless the pipeline is frozen.
// When the receiver holds m_axis_tready low while the output register is
// full, the whole pipeline freezes and s_axis_tready drops; nothing is
// lost or repeated. Reset clears all valid bits; the year table is a
// constant ROM. range_error results carry zero lunar fields but keep the
// stem and branch indices.
module gregorian_to_lunar_date #(
    parameter int TABLE_YEARS = g2l_pkg::TableYears,
    parameter int FIRST_YEAR  = g2l_pkg::FirstYear
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // greg_year[11:0], greg_month[15:12], greg_day[20:16], zero [23:21]
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // lunar_month[3:0], lunar_day[8:4], leap_flag[9], day_in_lunar_year[18:10],
    // stem_index[22:19], branch_index[26:23], range_error[27], zero [31:28]
    output logic [31:0] m_axis_tdata
);

    localparam int Steps = g2l_pkg::MonthSteps;

    logic advance;
    g2l_pkg::greg_t greg;

    assign greg.year  = s_axis_tdata[11:0];
    assign greg.month = s_axis_tdata[15:12];
    assign greg.day   = s_axis_tdata[20:16];

    // advance whenever the output slot is free or being drained
    assign advance = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    logic                f_valid;
    g2l_pkg::year_word_t f_word;
    logic [8:0]          f_pos;
    logic                f_err;
    logic [3:0]          f_stem, f_branch;

    g2l_front #(
        .TABLE_YEARS(TABLE_YEARS),
        .FIRST_YEAR (FIRST_YEAR)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s_axis_tvalid),
        .in_data   (greg),
        .out_valid (f_valid),
        .out_word  (f_word),
        .out_pos   (f_pos),
        .out_err   (f_err),
        .out_stem  (f_stem),
        .out_branch(f_branch)
    );

    logic                st_valid [Steps+1];
    g2l_pkg::year_word_t st_word  [Steps+1];
    logic [8:0]          st_pos   [Steps+1];
    logic [3:0]          st_m     [Steps+1];
    logic [3:0]          st_lumon [Steps+1];
    logic                st_leap  [Steps+1];
    logic                st_err   [Steps+1];
    logic [8:0]          st_doy   [Steps+1];
    logic [3:0]          st_stem  [Steps+1];
    logic [3:0]          st_branch[Steps+1];

    assign st_valid[0]  = f_valid;
    assign st_word[0]   = f_word;
    assign st_pos[0]    = f_pos;
    assign st_m[0]      = 4'd1;
    assign st_lumon[0]  = 4'd1;
    assign st_leap[0]   = 1'b0;
    assign st_err[0]    = f_err;
    assign st_doy[0]    = f_pos + 9'd1;
    assign st_stem[0]   = f_stem;
    assign st_branch[0] = f_branch;

    for (genvar i = 0; i < Steps; i++)
    begin : g_walk
        g2l_month_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (st_valid[i]),
            .in_word   (st_word[i]),
            .in_pos    (st_pos[i]),
            .in_m      (st_m[i]),
            .in_lumon  (st_lumon[i]),
            .in_leap   (st_leap[i]),
            .in_err    (st_err[i]),
            .in_doy    (st_doy[i]),
            .in_stem   (st_stem[i]),
            .in_branch (st_branch[i]),
            .out_valid (st_valid[i+1]),
            .out_word  (st_word[i+1]),
            .out_pos   (st_pos[i+1]),
            .out_m     (st_m[i+1]),
            .out_lumon (st_lumon[i+1]),
            .out_leap  (st_leap[i+1]),
            .out_err   (st_err[i+1]),
            .out_doy   (st_doy[i+1]),
            .out_stem  (st_stem[i+1]),
            .out_branch(st_branch[i+1])
        );
    end

    g2l_pkg::lunar_t res_next;
    logic [8:0]      pos_sat;

    always_comb
    begin
        pos_sat = (st_pos[Steps] > 9'd29) ? 9'd29 : st_pos[Steps];
        res_next.stem_index   = st_stem[Steps];
        res_next.branch_index = st_branch[Steps];
        res_next.range_error  = st_err[Steps];
        if (st_err[Steps])
        begin
            res_next.lunar_month       = 4'd0;
            res_next.lunar_day         = 5'd0;
            res_next.leap_flag         = 1'b0;
            res_next.day_in_lunar_year = 9'd0;
        end
        else
        begin
            res_next.lunar_month       = st_lumon[Steps];
            res_next.lunar_day         = pos_sat[4:0] + 5'd1;
            res_next.leap_flag         = st_leap[Steps];
            res_next.day_in_lunar_year = st_doy[Steps];
        end
    end

    logic            out_valid_reg;
    g2l_pkg::lunar_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= st_valid[Steps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_reg.range_error, out_reg.branch_index,
                            out_reg.stem_index, out_reg.day_in_lunar_year,
                            out_reg.leap_flag, out_reg.lunar_day, out_reg.lunar_month};

endmodule
